// ===== hdl/chd_pkg.sv =====
// chd_pkg: shared types and constants of the compass heading drive
// no dependencies

package chd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [9:0]  DEG_FULL = 10'd360;
  localparam logic [9:0]  DEG_HALF = 10'd180;
  localparam logic [13:0] ACC_MAX  = 14'd1023;
  localparam logic [7:0]  CH_ZERO  = 8'd48;
  localparam logic [7:0]  CH_NINE  = 8'd57;

  localparam logic [8:0]  TARGET_RST = 9'd268;
  localparam logic [7:0]  GAIN_RST   = 8'd38;
  localparam logic [12:0] BASE_RST   = 13'd3456;
  localparam logic [14:0] LIMIT_RST  = 15'd6500;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_GAIN   = 2'd1,
    REG_BASE   = 2'd2,
    REG_LIMIT  = 2'd3
  } chd_reg_t;

  typedef struct packed {
    logic [8:0]  target_heading;
    logic [7:0]  gain;
    logic [12:0] base_speed;
    logic [14:0] drive_limit;
  } chd_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } chd_qstat_t;

  typedef struct packed {
    logic [15:0] right_duty;
    logic        right_forward;
    logic [15:0] left_duty;
    logic        left_forward;
    logic [8:0]  heading_error;
    logic [8:0]  heading;
  } chd_result_t;

endpackage

// ===== hdl/chd_front.sv =====
// chd_front: parses received characters into completed headings
// depends on chd_pkg

module chd_front import chd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_acc,
  input  logic [7:0]  rx_byte,
  output logic        push,
  output logic [8:0]  push_heading
);

  logic        in_number_r, in_number_nxt;
  logic [9:0]  acc_r, acc_nxt;
  logic        digit;
  logic [3:0]  dval;
  logic [13:0] acc_ext;

  assign digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign dval    = 4'(rx_byte - CH_ZERO);
  assign acc_ext = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {10'd0, dval};

  always_comb begin
    in_number_nxt = in_number_r;
    acc_nxt       = acc_r;
    push          = 1'b0;
    if (byte_acc) begin
      if (!in_number_r) begin
        if (digit) begin
          in_number_nxt = 1'b1;
          acc_nxt       = {6'd0, dval};
        end
      end else if (digit) begin
        acc_nxt = (acc_ext > ACC_MAX) ? ACC_MAX[9:0] : acc_ext[9:0];
      end else begin
        in_number_nxt = 1'b0;
        acc_nxt       = 10'd0;
        push          = (acc_r < DEG_FULL);
      end
    end
  end

  assign push_heading = acc_r[8:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r <= 1'b0;
      acc_r       <= 10'd0;
    end else begin
      in_number_r <= in_number_nxt;
      acc_r       <= acc_nxt;
    end
  end

endmodule

// ===== hdl/chd_queue.sv =====
// chd_queue: short heading queue between parser and drive pipeline
// depends on chd_pkg

module chd_queue import chd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [8:0] push_data,
  input  logic       pop,
  output logic [8:0] pop_data,
  output chd_qstat_t stat
);

  logic [8:0]   mem_r [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/chd_back.sv =====
// chd_back: heading error, gain multiply, clamp and wheel drive pipeline
// depends on chd_pkg

module chd_back import chd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  chd_cfg_t    cfg,
  input  chd_qstat_t  qstat,
  input  logic [8:0]  q_heading,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_ready,
  output chd_result_t res
);

  // stage 1: error
  logic              s1_v_r;
  logic [8:0]        s1_hd_r;
  logic signed [8:0] s1_err_r;
  // stage 2: product
  logic              s2_v_r;
  logic [8:0]        s2_hd_r;
  logic signed [8:0] s2_err_r;
  logic signed [17:0] s2_prod_r;
  // stage 3: output
  logic              out_v_r;
  chd_result_t       out_r, out_nxt;

  logic out_adv, s2_adv, s1_adv;

  assign out_adv = !out_v_r || res_ready;
  assign s2_adv  = !s2_v_r || out_adv;
  assign s1_adv  = !s1_v_r || s2_adv;
  assign pop     = !qstat.empty && s1_adv;

  logic [9:0]         h10, t10, d_up, d_dn;
  logic signed [10:0] e11;

  always_comb begin
    h10  = {1'b0, q_heading};
    t10  = {1'b0, cfg.target_heading};
    d_up = t10 - h10;
    d_dn = h10 - t10;
    if (t10 >= h10) begin
      if (d_up >= DEG_HALF) begin
        e11 = $signed({1'b0, DEG_FULL}) - $signed({1'b0, d_up});
      end else begin
        e11 = -$signed({1'b0, d_up});
      end
    end else begin
      if (d_dn > DEG_HALF) begin
        e11 = $signed({1'b0, d_dn}) - $signed({1'b0, DEG_FULL});
      end else begin
        e11 = $signed({1'b0, d_dn});
      end
    end
  end

  logic signed [17:0] prod;
  assign prod = $signed({10'd0, cfg.gain}) * $signed({{9{s1_err_r[8]}}, s1_err_r});

  logic signed [17:0] lim, rv, base, lw, rw;

  always_comb begin
    lim  = $signed({3'd0, cfg.drive_limit});
    base = $signed({5'd0, cfg.base_speed});
    if (s2_prod_r < -lim) begin
      rv = -lim;
    end else if (s2_prod_r > lim) begin
      rv = lim;
    end else begin
      rv = s2_prod_r;
    end
    if (s2_err_r >= 0) begin
      lw = base - rv;
      rw = base;
    end else begin
      lw = base;
      rw = base + rv;
    end
    out_nxt.heading       = s2_hd_r;
    out_nxt.heading_error = s2_err_r;
    out_nxt.left_forward  = !lw[17];
    out_nxt.left_duty     = lw[17] ? 16'(-lw) : lw[15:0];
    out_nxt.right_forward = !rw[17];
    out_nxt.right_duty    = rw[17] ? 16'(-rw) : rw[15:0];
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_hd_r  <= q_heading;
      s1_err_r <= e11[8:0];
    end
    if (s2_adv) begin
      s2_hd_r   <= s1_hd_r;
      s2_err_r  <= s1_err_r;
      s2_prod_r <= prod;
    end
    if (out_adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= pop;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

endmodule

// ===== hdl/compass_heading_drive.sv =====
// compass_heading_drive: heading parser and proportional differential drive
// depends on chd_pkg, chd_front, chd_queue, chd_back
//
//  port group | dir | word
//  in_        | in  | rx_byte
//  out_       | out | heading, heading_error, wheel directions and duties
//  cfg_       | in  | target, gain, base speed, drive limit
//
// one byte per cycle while in_tready is high; queued headings feed the pipeline
// pipeline: error, gain multiply, clamp and wheel adds, each one register
// rst_n is synchronous; config registers return to their documented defaults
// in_tready drops only while the four-entry heading queue is full

module compass_heading_drive import chd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // heading, heading_error, left_forward, left_duty, right_forward, right_duty
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  chd_cfg_t    cfg_r;
  chd_qstat_t  qstat;
  chd_result_t res;
  logic        push, pop, byte_acc;
  logic [8:0]  push_heading, q_heading;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading <= TARGET_RST;
      cfg_r.gain           <= GAIN_RST;
      cfg_r.base_speed     <= BASE_RST;
      cfg_r.drive_limit    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (chd_reg_t'(cfg_addr))
        REG_TARGET: cfg_r.target_heading <= cfg_wdata[8:0];
        REG_GAIN:   cfg_r.gain           <= cfg_wdata[7:0];
        REG_BASE:   cfg_r.base_speed     <= cfg_wdata[12:0];
        REG_LIMIT:  cfg_r.drive_limit    <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !qstat.full;
  assign byte_acc  = in_tvalid && in_tready;

  chd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_acc     (byte_acc),
    .rx_byte      (in_tdata),
    .push         (push),
    .push_heading (push_heading)
  );

  chd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_heading),
    .pop       (pop),
    .pop_data  (q_heading),
    .stat      (qstat)
  );

  chd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .qstat     (qstat),
    .q_heading (q_heading),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {4'd0, res};

endmodule

// ===== sim/compass_heading_drive_tb.sv =====
// compass_heading_drive_tb: self-checking bench for the compass heading drive
// streams compass bytes, predicts each heading and wheel drive word, checks out_tdata
// depends on chd_pkg and compass_heading_drive
`timescale 1ns / 1ps

module compass_heading_drive_tb;
  import chd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int ITEM_GOAL = 500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [14:0] cfg_wdata = '0;

  compass_heading_drive dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  int cyc = 0;
  int hold_until = 0;
  bit calm = 1'b0;
  int mismatches = 0;
  int items_sent = 0;

  // register mirror and parser state
  int cfg_target = int'(TARGET_RST);
  int cfg_gain = int'(GAIN_RST);
  int cfg_base = int'(BASE_RST);
  int cfg_limit = int'(LIMIT_RST);
  bit run_on = 1'b0;
  int run_val = 0;

  chd_result_t expected_drive[$];
  chd_result_t got_drive;
  chd_result_t want_drive;

  always @(posedge clk) cyc <= cyc + 1;

  initial begin
    wait (cyc >= LIMIT);
    $display("timeout at cycle %0d", cyc);
    $display("compass_heading_drive_tb: done, errors");
    $finish;
  end

  // receiver: random stalls, calm stretches, long hold-offs
  always @(posedge clk) begin
    if (cyc < hold_until) begin
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 37);
    end
  end

  task automatic cmp_field(input string fname, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at cycle %0d: expected %0d, got %0d", fname, cyc, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_drive = out_tdata[51:0];
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word at cycle %0d: %h", cyc, out_tdata);
      end else begin
        want_drive = expected_drive.pop_front();
        cmp_field("heading", int'(want_drive.heading), int'(got_drive.heading));
        cmp_field("heading_error", int'($signed(want_drive.heading_error)),
                  int'($signed(got_drive.heading_error)));
        cmp_field("left_forward", int'(want_drive.left_forward),
                  int'(got_drive.left_forward));
        cmp_field("left_duty", int'(want_drive.left_duty), int'(got_drive.left_duty));
        cmp_field("right_forward", int'(want_drive.right_forward),
                  int'(got_drive.right_forward));
        cmp_field("right_duty", int'(want_drive.right_duty), int'(got_drive.right_duty));
        cmp_field("pad", 0, int'(out_tdata[55:52]));
      end
    end
  end

  // parse one byte and queue the drive word it completes
  task automatic predict_drive(input logic [7:0] b);
    chd_result_t r;
    int ch, hd, err, rv, lw, rw;
    bit dig;
    ch = int'(b);
    dig = (ch >= int'(CH_ZERO)) && (ch <= int'(CH_NINE));
    if (!run_on) begin
      if (dig) begin
        run_on = 1'b1;
        run_val = ch - int'(CH_ZERO);
      end
      return;
    end
    if (dig) begin
      run_val = run_val * 10 + (ch - int'(CH_ZERO));
      if (run_val > int'(ACC_MAX)) run_val = int'(ACC_MAX);
      return;
    end
    hd = run_val;
    run_on = 1'b0;
    run_val = 0;
    if (hd >= int'(DEG_FULL)) return;
    if (cfg_target >= hd) begin
      if (cfg_target - hd >= 360 + hd - cfg_target) err = 360 + hd - cfg_target;
      else err = hd - cfg_target;
    end else begin
      if (hd - cfg_target > 360 + cfg_target - hd) err = hd - 360 - cfg_target;
      else err = hd - cfg_target;
    end
    rv = cfg_gain * err;
    if (rv < -cfg_limit) rv = -cfg_limit;
    else if (rv > cfg_limit) rv = cfg_limit;
    lw = cfg_base;
    rw = cfg_base;
    if (err >= 0) lw = cfg_base - rv;
    else rw = cfg_base + rv;
    r.heading = hd[8:0];
    r.heading_error = err[8:0];
    r.left_forward = (lw >= 0);
    r.left_duty = 16'((lw < 0) ? -lw : lw);
    r.right_forward = (rw >= 0);
    r.right_duty = 16'((rw < 0) ? -rw : rw);
    expected_drive.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_drive(b);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input chd_reg_t idx, input int val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[14:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TARGET: cfg_target = val & 'h1FF;
      REG_GAIN:   cfg_gain = val & 'hFF;
      REG_BASE:   cfg_base = val & 'h1FFF;
      REG_LIMIT:  cfg_limit = val & 'h7FFF;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int t, input int g, input int bs, input int lim);
    drain();
    write_reg(REG_TARGET, t);
    write_reg(REG_GAIN, g);
    write_reg(REG_BASE, bs);
    write_reg(REG_LIMIT, lim);
  endtask

  function automatic logic [7:0] pick_nondigit();
    int v;
    do v = $urandom_range(255); while (v >= int'(CH_ZERO) && v <= int'(CH_NINE));
    return v[7:0];
  endfunction

  // optional leading zero, digits of val, then a terminator
  task automatic send_heading(input int val, input bit lead_zero, input logic [7:0] term);
    string s;
    s = $sformatf("%0d", val);
    if (lead_zero) s = {"0", s};
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(term);
    items_sent += s.len() + 1;
  endtask

  // one well-formed run with random content, sometimes noise or an oversized run
  task automatic random_sequence();
    int pick, n;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(pick_nondigit());
    end
    if (pick < 78) begin
      send_heading($urandom_range(359), ($urandom_range(9) == 0), pick_nondigit());
    end else if (pick < 90) begin
      send_heading($urandom_range(1023, 360), 1'b0, pick_nondigit());
    end else begin
      n = $urandom_range(7, 4);
      repeat (n) send_byte(8'(CH_ZERO + $urandom_range(9)));
      send_byte(pick_nondigit());
      items_sent += n + 1;
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_NINE + 8'd1);
    send_heading(0, 1'b0, CH_ZERO - 8'd1);
    send_heading(359, 1'b0, CH_NINE + 8'd1);
    send_heading(360, 1'b0, 8'h00);
    send_heading(268, 1'b0, 8'hFF);
    send_heading(88, 1'b0, " ");
    send_heading(89, 1'b1, "\n");
    send_heading(99999, 1'b0, ",");
    drain();
  endtask

  task automatic test_settings();
    int t, g, bs, lim;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin t = 0;   g = 255; bs = 0;    lim = 32767; end
        1: begin t = 511; g = 1;   bs = 8191; lim = 0;     end
        2: begin t = 359; g = 0;   bs = 8191; lim = 32767; end
        3: begin t = 400; g = 255; bs = 100;  lim = 32767; end
        default: begin
          t = $urandom_range(511);
          g = $urandom_range(255);
          bs = $urandom_range(8191);
          lim = $urandom_range(32767);
        end
      endcase
      apply_setting(t, g, bs, lim);
      send_heading(0, 1'b0, pick_nondigit());
      send_heading(359, 1'b0, pick_nondigit());
      send_heading((t + 180) % 360, 1'b0, pick_nondigit());
      repeat (8) random_sequence();
    end
    drain();
  endtask

  task automatic test_calm_stretch();
    calm = 1'b1;
    repeat (20) random_sequence();
    drain();
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_until = cyc + 300;
    repeat (24) send_heading($urandom_range(9), 1'b0, pick_nondigit());
    drain();
    calm = 1'b0;
  endtask

  task automatic test_random_mix();
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(9) == 0)
        apply_setting($urandom_range(511), $urandom_range(255),
                      $urandom_range(8191), $urandom_range(32767));
      repeat (6) random_sequence();
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_settings();
    test_calm_stretch();
    test_backpressure();
    test_random_mix();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("compass_heading_drive_tb: done, clean");
    end else begin
      $display("compass_heading_drive_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== compass_heading_drive.f =====
hdl/chd_pkg.sv
hdl/chd_front.sv
hdl/chd_queue.sv
hdl/chd_back.sv
hdl/compass_heading_drive.sv
sim/compass_heading_drive_tb.sv
